FILE: rtl/core/rj_pkg.sv
// ----------------------------------------------------------------------------
// Radar Jacobian shared definitions
// Constants for the radar measurement Jacobian pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rj_pkg;

   // Width of the minimum squared range register and its value after reset.
   localparam int unsigned CSR_W = 32;
   localparam logic [CSR_W-1:0] MIN_RANGE_SQ_RST = 32'd7;

   // Number of distinct Jacobian entries carried in one result beat.
   localparam int unsigned NUM_ENTRIES = 6;

   // Positions of the entries in the sign vector and in the result beat.
   typedef enum logic [2:0] {
      ENT_DRANGE_DPX   = 3'd0,
      ENT_DRANGE_DPY   = 3'd1,
      ENT_DBEARING_DPX = 3'd2,
      ENT_DBEARING_DPY = 3'd3,
      ENT_DRATE_DPX    = 3'd4,
      ENT_DRATE_DPY    = 3'd5
   } rj_entry_type;

endpackage

`default_nettype wire

FILE: rtl/core/rj_div.sv
// ----------------------------------------------------------------------------
// Radar Jacobian pipelined divider
// Unsigned restoring divider, one quotient bit per register stage, with an
// overflow flag for quotients that do not fit in QUO_W-1 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rj_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32,
   parameter int QUO_W = 32
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QUO_W-2:0] quo,
   output logic                  ovf
);

   localparam int XW = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;

   logic [XW-1:0]    num_x;
   logic [XW-1:0]    lim_x;
   logic [XW-1:0]    top_x;

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-2:0] low_ff [QUO_W];
   logic [QUO_W-2:0] quo_ff [QUO_W];
   logic             ovf_ff [QUO_W];

   assign num_x = XW'(num);
   assign lim_x = XW'(den) << (QUO_W - 1);
   assign top_x = num_x >> (QUO_W - 1);

   // The quotient saturates when num >= den * 2^(QUO_W-1); otherwise the
   // upper numerator bits are already below den and seed the remainder.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= top_x[DEN_W-1:0];
         den_ff[0] <= den;
         low_ff[0] <= num[QUO_W-2:0];
         quo_ff[0] <= '0;
         ovf_ff[0] <= (num_x >= lim_x);
      end
   end

   for (genvar k = 1; k < QUO_W; k++) begin : g_step
      localparam int BI = QUO_W - 1 - k;
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;

      assign trial = {rem_ff[k-1], low_ff[k-1][BI]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      assign ge    = (trial >= {1'b0, den_ff[k-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[k] <= den_ff[k-1];
            low_ff[k] <= low_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | ((QUO_W-1)'(ge) << BI);
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];
   assign ovf = ovf_ff[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/radar_jacobian_top.sv
// Throughput: one beat per cycle; every stage advances together whenever the
//   output register is empty or being taken.
// Reset: synchronous, active high; it empties the pipeline and sets
//   min_range_sq to 7.
// ----------------------------------------------------------------------------
// Radar measurement Jacobian
// Computes the six distinct entries of the range, bearing and range-rate
// Jacobian for one tracked state in a fully pipelined datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_jacobian_top #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // Input beat, fields from bit 0 up: pos_x, pos_y, vel_x, vel_y.
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]         req_tdata,
   // Result beat, fields from bit 0 up: drange_dpx, drange_dpy,
   // dbearing_dpx, dbearing_dpy, drate_dpx, drate_dpy.
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   output logic      [((6*DATA_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // Result flag: range_too_small.
   output logic                                           rsp_tuser,
   // Minimum squared range register write.
   input  wire logic                                      csr_wr_en,
   input  wire logic [rj_pkg::CSR_W-1:0]                  csr_wr_data
);

   import rj_pkg::*;

   localparam int W      = DATA_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int W2     = 2 * W;
   localparam int W3     = 3 * W;
   localparam int IN_TW  = ((4 * W + 7) / 8) * 8;
   localparam int OUT_TW = ((6 * W + 7) / 8) * 8;
   localparam int CW     = (W2 > CSR_W + F) ? W2 : CSR_W + F;
   localparam int SW     = W2 + 2;

   // The whole pipeline moves as one: it advances whenever the output
   // register can take a new beat.
   logic en;

   logic [CSR_W-1:0] min_range_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_sq_ff <= MIN_RANGE_SQ_RST;
      end else if (csr_wr_en) begin
         min_range_sq_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------------
   // Stage A: split each input field into sign and magnitude. The magnitude
   // keeps all W bits so that the most negative value stays exact.
   // ------------------------------------------------------------------------
   logic [W-1:0] in_field [4];
   logic [W-1:0] in_mag   [4];
   logic         in_neg   [4];

   logic         a_vld_ff;
   logic [W-1:0] a_mag_ff [4];
   logic         a_neg_ff [4];

   for (genvar i = 0; i < 4; i++) begin : g_dec
      assign in_field[i] = req_tdata[i*W +: W];
      assign in_neg[i]   = in_field[i][W-1];
      assign in_mag[i]   = in_neg[i] ? (~in_field[i] + W'(1)) : in_field[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            a_mag_ff[i] <= in_mag[i];
            a_neg_ff[i] <= in_neg[i];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage B: the four magnitude products, px^2, py^2, vx*py and vy*px.
   // The signs of the two cross terms are resolved here as well.
   // ------------------------------------------------------------------------
   logic          b_vld_ff;
   logic [W2-1:0] b_pp_ff, b_qq_ff, b_a_ff, b_b_ff;
   logic [W-1:0]  b_pm_ff, b_qm_ff;
   logic          b_pn_ff, b_qn_ff, b_an_ff, b_bn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_pp_ff <= W2'(a_mag_ff[0]) * W2'(a_mag_ff[0]);
         b_qq_ff <= W2'(a_mag_ff[1]) * W2'(a_mag_ff[1]);
         b_a_ff  <= W2'(a_mag_ff[2]) * W2'(a_mag_ff[1]);
         b_b_ff  <= W2'(a_mag_ff[3]) * W2'(a_mag_ff[0]);
         b_pm_ff <= a_mag_ff[0];
         b_qm_ff <= a_mag_ff[1];
         b_pn_ff <= a_neg_ff[0];
         b_qn_ff <= a_neg_ff[1];
         // vx*py carries the sign of vx times py; -vy*px the inverse of vy*px.
         b_an_ff <= a_neg_ff[2] ^ a_neg_ff[1];
         b_bn_ff <= ~(a_neg_ff[3] ^ a_neg_ff[0]);
      end
   end

   // ------------------------------------------------------------------------
   // Stage C: the squared range S, the cross term d = vx*py - vy*px in sign
   // and magnitude, and the range check. A zero S is always flagged since
   // every divisor would be zero.
   // ------------------------------------------------------------------------
   logic [W2-1:0]        c_s;
   logic signed [SW-1:0] c_sa, c_sb, c_dsum;
   logic                 c_dn;
   logic [SW-1:0]        c_dabs;
   logic [CW-1:0]        c_lim;
   logic                 c_small;

   assign c_s    = b_pp_ff + b_qq_ff;
   assign c_sa   = b_an_ff ? -$signed(SW'(b_a_ff)) : $signed(SW'(b_a_ff));
   assign c_sb   = b_bn_ff ? -$signed(SW'(b_b_ff)) : $signed(SW'(b_b_ff));
   assign c_dsum = c_sa + c_sb;
   assign c_dn   = c_dsum[SW-1];
   assign c_dabs = c_dn ? SW'(-c_dsum) : SW'(c_dsum);
   assign c_lim  = CW'(min_range_sq_ff) << F;
   assign c_small = (CW'(c_s) < c_lim) || (c_s == '0);

   // The square root works through W stages, one root bit per stage.
   // Index 0 holds stage C; index k+1 holds the result of root step k.
   logic          t_vld_ff   [W+1];
   logic [W2-1:0] t_rem_ff   [W+1];
   logic [W-1:0]  t_root_ff  [W+1];
   logic [W2-1:0] t_s_ff     [W+1];
   logic [W-1:0]  t_pm_ff    [W+1];
   logic [W-1:0]  t_qm_ff    [W+1];
   logic [W2-1:0] t_dm_ff    [W+1];
   logic          t_pn_ff    [W+1];
   logic          t_qn_ff    [W+1];
   logic          t_dn_ff    [W+1];
   logic          t_small_ff [W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff[0] <= 1'b0;
      end else if (en) begin
         t_vld_ff[0] <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_rem_ff[0]   <= c_s;
         t_root_ff[0]  <= '0;
         t_s_ff[0]     <= c_s;
         t_pm_ff[0]    <= b_pm_ff;
         t_qm_ff[0]    <= b_qm_ff;
         t_dm_ff[0]    <= c_dabs[W2-1:0];
         t_pn_ff[0]    <= b_pn_ff;
         t_qn_ff[0]    <= b_qn_ff;
         t_dn_ff[0]    <= c_dn;
         t_small_ff[0] <= c_small;
      end
   end

   // Digit-by-digit root: the remainder holds S - y^2, and bit B is kept
   // when (y + 2^B)^2 still fits, that is when the remainder covers
   // 2*y*2^B + 2^(2B).
   for (genvar k = 0; k < W; k++) begin : g_root
      localparam int B = W - 1 - k;
      logic [W2:0] trial;
      logic [W2:0] diff;
      logic        ge;

      assign trial = ((W2+1)'(t_root_ff[k]) << (B + 1)) + ((W2+1)'(1) << (2 * B));
      assign diff  = {1'b0, t_rem_ff[k]} - trial;
      assign ge    = ({1'b0, t_rem_ff[k]} >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            t_vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            t_vld_ff[k+1] <= t_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            t_rem_ff[k+1]   <= ge ? diff[W2-1:0] : t_rem_ff[k];
            t_root_ff[k+1]  <= t_root_ff[k] | (W'(ge) << B);
            t_s_ff[k+1]     <= t_s_ff[k];
            t_pm_ff[k+1]    <= t_pm_ff[k];
            t_qm_ff[k+1]    <= t_qm_ff[k];
            t_dm_ff[k+1]    <= t_dm_ff[k];
            t_pn_ff[k+1]    <= t_pn_ff[k];
            t_qn_ff[k+1]    <= t_qn_ff[k];
            t_dn_ff[k+1]    <= t_dn_ff[k];
            t_small_ff[k+1] <= t_small_ff[k];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage M1: half-width partial products of c3 = S*R and of the drate
   // numerators py*|d| and px*|d|. Each multiplier is W by W bits.
   // ------------------------------------------------------------------------
   logic          m_vld_ff;
   logic [W2-1:0] m_c3lo_ff, m_c3hi_ff, m_nqlo_ff, m_nqhi_ff, m_nplo_ff, m_nphi_ff;
   logic [W2-1:0] m_s_ff;
   logic [W-1:0]  m_r_ff, m_pm_ff, m_qm_ff;
   logic          m_pn_ff, m_qn_ff, m_dn_ff, m_small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff <= t_vld_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_c3lo_ff  <= W2'(t_s_ff[W][W-1:0])  * W2'(t_root_ff[W]);
         m_c3hi_ff  <= W2'(t_s_ff[W][W2-1:W]) * W2'(t_root_ff[W]);
         m_nqlo_ff  <= W2'(t_qm_ff[W]) * W2'(t_dm_ff[W][W-1:0]);
         m_nqhi_ff  <= W2'(t_qm_ff[W]) * W2'(t_dm_ff[W][W2-1:W]);
         m_nplo_ff  <= W2'(t_pm_ff[W]) * W2'(t_dm_ff[W][W-1:0]);
         m_nphi_ff  <= W2'(t_pm_ff[W]) * W2'(t_dm_ff[W][W2-1:W]);
         m_s_ff     <= t_s_ff[W];
         m_r_ff     <= t_root_ff[W];
         m_pm_ff    <= t_pm_ff[W];
         m_qm_ff    <= t_qm_ff[W];
         m_pn_ff    <= t_pn_ff[W];
         m_qn_ff    <= t_qn_ff[W];
         m_dn_ff    <= t_dn_ff[W];
         m_small_ff <= t_small_ff[W];
      end
   end

   // ------------------------------------------------------------------------
   // Stage M2: the partial products are joined into full 3W-bit values, and
   // the signs of the six entries are settled.
   // ------------------------------------------------------------------------
   logic                   n_vld_ff;
   logic [W3-1:0]          n_c3_ff, n_nq_ff, n_np_ff;
   logic [W2-1:0]          n_s_ff;
   logic [W-1:0]           n_r_ff, n_pm_ff, n_qm_ff;
   logic [NUM_ENTRIES-1:0] n_neg_ff;
   logic                   n_small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
      end else if (en) begin
         n_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_c3_ff    <= W3'(m_c3lo_ff) + (W3'(m_c3hi_ff) << W);
         n_nq_ff    <= W3'(m_nqlo_ff) + (W3'(m_nqhi_ff) << W);
         n_np_ff    <= W3'(m_nplo_ff) + (W3'(m_nphi_ff) << W);
         n_s_ff     <= m_s_ff;
         n_r_ff     <= m_r_ff;
         n_pm_ff    <= m_pm_ff;
         n_qm_ff    <= m_qm_ff;
         n_neg_ff[ENT_DRANGE_DPX]   <= m_pn_ff;
         n_neg_ff[ENT_DRANGE_DPY]   <= m_qn_ff;
         n_neg_ff[ENT_DBEARING_DPX] <= ~m_qn_ff;
         n_neg_ff[ENT_DBEARING_DPY] <= m_pn_ff;
         n_neg_ff[ENT_DRATE_DPX]    <= m_qn_ff ^ m_dn_ff;
         n_neg_ff[ENT_DRATE_DPY]    <= m_pn_ff ^ ~m_dn_ff;
         n_small_ff <= m_small_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Division: six dividers of W stages each run side by side. The valid
   // bit, the signs and the range flag travel beside them.
   // ------------------------------------------------------------------------
   logic [W-2:0] div_quo [NUM_ENTRIES];
   logic         div_ovf [NUM_ENTRIES];

   rj_div #(.NUM_W(W + F), .DEN_W(W), .QUO_W(W)) u_div_rpx (
      .clock (clock), .en (en),
      .num ((W + F)'(n_pm_ff) << F), .den (n_r_ff),
      .quo (div_quo[ENT_DRANGE_DPX]), .ovf (div_ovf[ENT_DRANGE_DPX])
   );

   rj_div #(.NUM_W(W + F), .DEN_W(W), .QUO_W(W)) u_div_rpy (
      .clock (clock), .en (en),
      .num ((W + F)'(n_qm_ff) << F), .den (n_r_ff),
      .quo (div_quo[ENT_DRANGE_DPY]), .ovf (div_ovf[ENT_DRANGE_DPY])
   );

   rj_div #(.NUM_W(W + 2 * F), .DEN_W(W2), .QUO_W(W)) u_div_bpx (
      .clock (clock), .en (en),
      .num ((W + 2 * F)'(n_qm_ff) << (2 * F)), .den (n_s_ff),
      .quo (div_quo[ENT_DBEARING_DPX]), .ovf (div_ovf[ENT_DBEARING_DPX])
   );

   rj_div #(.NUM_W(W + 2 * F), .DEN_W(W2), .QUO_W(W)) u_div_bpy (
      .clock (clock), .en (en),
      .num ((W + 2 * F)'(n_pm_ff) << (2 * F)), .den (n_s_ff),
      .quo (div_quo[ENT_DBEARING_DPY]), .ovf (div_ovf[ENT_DBEARING_DPY])
   );

   rj_div #(.NUM_W(W3 + F), .DEN_W(W3), .QUO_W(W)) u_div_dpx (
      .clock (clock), .en (en),
      .num ((W3 + F)'(n_nq_ff) << F), .den (n_c3_ff),
      .quo (div_quo[ENT_DRATE_DPX]), .ovf (div_ovf[ENT_DRATE_DPX])
   );

   rj_div #(.NUM_W(W3 + F), .DEN_W(W3), .QUO_W(W)) u_div_dpy (
      .clock (clock), .en (en),
      .num ((W3 + F)'(n_np_ff) << F), .den (n_c3_ff),
      .quo (div_quo[ENT_DRATE_DPY]), .ovf (div_ovf[ENT_DRATE_DPY])
   );

   logic                   e_vld_ff   [W];
   logic [NUM_ENTRIES-1:0] e_neg_ff   [W];
   logic                   e_small_ff [W];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff[0] <= 1'b0;
      end else if (en) begin
         e_vld_ff[0] <= n_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_neg_ff[0]   <= n_neg_ff;
         e_small_ff[0] <= n_small_ff;
      end
   end

   for (genvar k = 1; k < W; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            e_vld_ff[k] <= 1'b0;
         end else if (en) begin
            e_vld_ff[k] <= e_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            e_neg_ff[k]   <= e_neg_ff[k-1];
            e_small_ff[k] <= e_small_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output register: apply the sign, saturate to the signed W-bit range,
   // and zero every entry of a flagged beat.
   // ------------------------------------------------------------------------
   function automatic logic [W-1:0] sat_entry(input logic neg, input logic ovf,
                                              input logic [W-2:0] mag);
      logic [W-1:0] pos;
      pos = {1'b0, mag};
      if (ovf) begin
         sat_entry = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         sat_entry = neg ? (~pos + W'(1)) : pos;
      end
   endfunction

   logic [W*NUM_ENTRIES-1:0] out_entries;

   for (genvar j = 0; j < NUM_ENTRIES; j++) begin : g_enc
      assign out_entries[j*W +: W] = e_small_ff[W-1] ? '0 :
         sat_entry(e_neg_ff[W-1][j], div_ovf[j], div_quo[j]);
   end

   logic              rsp_tvalid_ff;
   logic [OUT_TW-1:0] rsp_tdata_ff;
   logic              rsp_tuser_ff;

   assign en = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= e_vld_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= OUT_TW'(out_entries);
         rsp_tuser_ff <= e_small_ff[W-1];
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // A flagged result carries all-zero entries.
   a_small_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("flagged result has nonzero entries");

   // The root leaving the last root step is the floor square root of S.
   a_root_floor : assert property (@(posedge clock) disable iff (reset)
      t_vld_ff[W] |->
         ((W2+2)'(t_root_ff[W]) * (W2+2)'(t_root_ff[W]) <= (W2+2)'(t_s_ff[W])) &&
         (((W2+2)'(t_root_ff[W]) + (W2+2)'(1)) * ((W2+2)'(t_root_ff[W]) + (W2+2)'(1))
            > (W2+2)'(t_s_ff[W])))
      else $error("square root stage gave a wrong root");

   // px over the range never exceeds one in magnitude.
   a_range_unit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         ($signed(rsp_tdata[W-1:0]) <= $signed(65'(1) << F)) &&
         ($signed(rsp_tdata[W-1:0]) >= -$signed(65'(1) << F)))
      else $error("drange_dpx outside of the unit range");

endmodule

`default_nettype wire

FILE: bench/tb_radar_jacobian_top.sv
// ----------------------------------------------------------------------------
// Radar Jacobian testbench
// Drives tracked states into the Jacobian pipeline with random gaps and
// back-pressure, predicts every entry with exact wide integer arithmetic and
// checks each result beat in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_radar_jacobian_top;
   import rj_pkg::*;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int LATENCY    = 2 * DATA_WIDTH + 6;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] vel_y;
      logic [31:0] vel_x;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
   } track_state_type;

   typedef struct packed {
      logic        too_small;
      logic [31:0] drate_dpy;
      logic [31:0] drate_dpx;
      logic [31:0] dbearing_dpy;
      logic [31:0] dbearing_dpx;
      logic [31:0] drange_dpy;
      logic [31:0] drange_dpx;
   } jacobian_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [191:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [31:0]  csr_wr_data = '0;

   radar_jacobian_top #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // The testbench's own copy of the minimum squared range register.
   logic [31:0]  min_range_sq_mirror = MIN_RANGE_SQ_RST;

   track_state_type pending_states[$];
   jacobian_type    expected_jacobians[$];
   int           mismatch_count = 0;
   int           result_count = 0;
   int           flagged_count = 0;
   int           cycle_count = 0;
   bit           gaps_on = 1'b1;
   bit           sender_hold = 1'b0;
   bit           req_taken = 1'b0;

   // Truncating signed quotient, saturated to the 32-bit signed range. The
   // 256-bit signed width holds every intermediate product exactly.
   function automatic logic [31:0] sat_quotient(input logic signed [255:0] num,
                                                input logic signed [255:0] den);
      logic signed [255:0] quot;
      quot = num / den;
      if (quot > 256'sd2147483647) return 32'h7fff_ffff;
      if (quot < -256'sd2147483648) return 32'h8000_0000;
      return quot[31:0];
   endfunction

   function automatic jacobian_type predict_jacobian(input track_state_type st);
      logic signed [255:0] px, py, vx, vy, sq_range, range, cube, cross_term;
      logic signed [255:0] lim;
      logic [63:0]         root;
      jacobian_type        jac;
      px = $signed(st.pos_x);
      py = $signed(st.pos_y);
      vx = $signed(st.vel_x);
      vy = $signed(st.vel_y);
      jac = '0;
      sq_range = px * px + py * py;
      lim = $signed({224'd0, min_range_sq_mirror}) <<< FRAC_BITS;
      if (sq_range == 0 || sq_range < lim) begin
         jac.too_small = 1'b1;
         return jac;
      end
      // Integer square root, bit by bit from the top.
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         logic [63:0] trial;
         trial = root | (64'd1 << b);
         if ($signed({192'd0, trial}) * $signed({192'd0, trial}) <= sq_range)
            root = trial;
      end
      range = $signed({192'd0, root});
      cube  = sq_range * range;
      cross_term = vx * py - vy * px;
      jac.drange_dpx   = sat_quotient(px <<< FRAC_BITS, range);
      jac.drange_dpy   = sat_quotient(py <<< FRAC_BITS, range);
      jac.dbearing_dpx = sat_quotient(-(py <<< (2 * FRAC_BITS)), sq_range);
      jac.dbearing_dpy = sat_quotient(px <<< (2 * FRAC_BITS), sq_range);
      jac.drate_dpx    = sat_quotient((py * cross_term) <<< FRAC_BITS, cube);
      jac.drate_dpy    = sat_quotient((-(px * cross_term)) <<< FRAC_BITS, cube);
      return jac;
   endfunction

   function automatic logic [31:0] random_coord();
      // Mostly moderate magnitudes so that the entries stay in range, with
      // some full-range words to reach saturation and every bit.
      case ($urandom_range(0, 9))
         0, 1: return $urandom();
         2:    return $signed($urandom_range(0, 16'hffff)) - 32'sd32768;
         default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      endcase
   endfunction

   // Input side: a beat is taken at the rising edge where valid and ready
   // are both high; it is predicted and dropped from the pending queue there.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_jacobians.push_back(predict_jacobian(req_tdata));
         void'(pending_states.pop_front());
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   // Driver: presents the oldest pending state at the falling edge, with
   // random gaps when enabled. A beat stays put until it has been taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (!sender_hold && pending_states.size() > 0 &&
                (!gaps_on || $urandom_range(0, 99) >= 32)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_states[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !gaps_on || ($urandom_range(0, 99) >= 32);
      end
   end

   // Monitor: takes each result beat at the rising edge and checks it
   // against the oldest prediction.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         jacobian_type got, want;
         got = {rsp_tuser, rsp_tdata};
         result_count <= result_count + 1;
         if (got.too_small) flagged_count <= flagged_count + 1;
         if (expected_jacobians.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("ERROR: unexpected result beat %h", got);
         end else begin
            want = expected_jacobians.pop_front();
            if (got !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("ERROR: result %0d exp %h got %h", result_count, want, got);
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout with %0d results outstanding", expected_jacobians.size());
         $display("tb_radar_jacobian_top failed");
         $finish;
      end
   end

   task automatic queue_state(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] vx, input logic [31:0] vy);
      track_state_type st;
      st.pos_x = px; st.pos_y = py; st.vel_x = vx; st.vel_y = vy;
      pending_states.push_back(st);
   endtask

   // Waits until the pipeline has drained, then lets its latency pass.
   task automatic drain_pipeline();
      while (pending_states.size() > 0 || req_tvalid || expected_jacobians.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_min_range(input logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      min_range_sq_mirror = value;
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++)
         queue_state(random_coord(), random_coord(), random_coord(), random_coord());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed states at the reset threshold: zero position, a point under
      // and a point over the minimum, the field extremes, and a small
      // position.
      queue_state(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
      queue_state(32'h0000_0002, 32'h0000_0001, 32'h0, 32'h0);
      queue_state(32'h0002_a000, 32'h0, 32'h0, 32'h0);
      queue_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      queue_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      queue_state(32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0);
      queue_state(32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
      queue_state(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hfffe_0000);
      queue_state(32'hfffd_0000, 32'h0004_0000, 32'h0005_0000, 32'h0002_0000);
      queue_state(32'h0000_0400, 32'hffff_fc00, 32'h7fff_0000, 32'h8001_0000);
      queue_state(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      queue_state(32'hffff_ffff, 32'hffff_ffff, 32'h1234_5678, 32'h9abc_def0);
      drain_pipeline();

      // With no minimum only a zero position is flagged.
      write_min_range(32'h0);
      queue_state(32'h0, 32'h0, 32'h1, 32'h1);
      queue_state(32'h0000_0001, 32'h0, 32'h0, 32'h1);
      queue_state(32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h0);
      queue_random(200);
      drain_pipeline();

      // The largest minimum flags nearly everything.
      write_min_range(32'hffff_ffff);
      queue_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
      queue_state(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
      queue_random(60);
      drain_pipeline();

      // A mid-range minimum, run first without any gaps on either side.
      write_min_range(32'h0100_0000);
      gaps_on = 1'b0;
      queue_random(200);
      drain_pipeline();
      gaps_on = 1'b1;

      // Back to the reset value; the sender holds once until all results
      // have come back before releasing the rest.
      write_min_range(MIN_RANGE_SQ_RST);
      queue_random(150);
      drain_pipeline();
      sender_hold = 1'b1;
      queue_random(30);
      while (expected_jacobians.size() > 0) @(posedge clock);
      sender_hold = 1'b0;
      queue_random(300);
      drain_pipeline();

      $display("Checked %0d result beats, %0d of them flagged as too close,",
               result_count, flagged_count);
      $display("over four minimum range settings with random gaps and stalls.");
      if (mismatch_count == 0) begin
         $display("tb_radar_jacobian_top passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_radar_jacobian_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
